/* rtl/aecc_pkg.sv */
// Package with the opcode, sequencer and request/response types of the execute unit.
`timescale 1ns / 1ps
`default_nettype none

package aecc_pkg;

  // Opcodes of the virtual machine; codes 22 to 31 are no-operations.
  typedef enum logic [4:0] {
    OP_MOV  = 5'd0,
    OP_ADD  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SWAP = 5'd3,
    OP_MUL  = 5'd4,
    OP_DIV  = 5'd5,
    OP_CMP  = 5'd6,
    OP_SHL  = 5'd7,
    OP_SHR  = 5'd8,
    OP_AND  = 5'd9,
    OP_OR   = 5'd10,
    OP_XOR  = 5'd11,
    OP_JMP  = 5'd12,
    OP_JZ   = 5'd13,
    OP_JP   = 5'd14,
    OP_JN   = 5'd15,
    OP_JNZ  = 5'd16,
    OP_JNP  = 5'd17,
    OP_JNN  = 5'd18,
    OP_LDL  = 5'd19,
    OP_LDH  = 5'd20,
    OP_NOT  = 5'd21
  } op_t;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_OUT
  } top_state_t;

  // Multiply/divide unit states.
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX,
    MD_DONE
  } md_state_t;

  // Request from the sequencer to the multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // Response of the multiply/divide unit; results hold until the next start.
  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } md_rsp_t;

  localparam logic [31:0] SEG_MASK = 32'hFFFF_0000;
  localparam logic [31:0] OFS_MASK = 32'h0000_FFFF;
  localparam logic [4:0]  LAST_STEP = 5'd31;

endpackage : aecc_pkg

`default_nettype wire

/* rtl/aecc_muldiv.sv */
// Iterative multiply and signed divide unit built around one shared 33-bit adder.
`timescale 1ns / 1ps
`default_nettype none

module aecc_muldiv (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire aecc_pkg::md_req_t req,
  input  wire logic [31:0]      opa,
  input  wire logic [31:0]      opb,
  output aecc_pkg::md_rsp_t     rsp
);
  import aecc_pkg::*;

  md_state_t   state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        is_div_r, is_div_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  // acc_r: product (multiply) or partial remainder (divide).
  // sh_r:  multiplier shifting right (multiply) or dividend/quotient (divide).
  // mc_r:  multiplicand shifting left (multiply) or divisor magnitude (divide).
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [31:0] mc_r, mc_nxt;

  logic [31:0] rem_sh;
  logic [31:0] add_x, add_y;
  logic [32:0] add_sum;

  // Shared adder: adds for multiply, trial subtract for divide.
  always_comb begin
    rem_sh  = {acc_r[30:0], sh_r[31]};
    add_x   = is_div_r ? rem_sh : acc_r;
    add_y   = is_div_r ? ~mc_r : (sh_r[0] ? mc_r : 32'd0);
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, is_div_r};
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    is_div_r <= is_div_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_r_r  <= neg_r_nxt;
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    mc_r     <= mc_nxt;
  end

  // Next state and datapath updates.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    is_div_nxt = is_div_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    acc_nxt    = acc_r;
    sh_nxt     = sh_r;
    mc_nxt     = mc_r;
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          state_nxt  = MD_RUN;
          cnt_nxt    = 5'd0;
          is_div_nxt = req.is_div;
          acc_nxt    = 32'd0;
          if (req.is_div) begin
            neg_q_nxt = opa[31] ^ opb[31];
            neg_r_nxt = opa[31];
            sh_nxt    = opa[31] ? (~opa + 32'd1) : opa;
            mc_nxt    = opb[31] ? (~opb + 32'd1) : opb;
          end else begin
            neg_q_nxt = 1'b0;
            neg_r_nxt = 1'b0;
            sh_nxt    = opb;
            mc_nxt    = opa;
          end
        end
      end
      MD_RUN: begin
        if (is_div_r) begin
          // Restoring division step: keep the difference when no borrow.
          acc_nxt = add_sum[32] ? add_sum[31:0] : rem_sh;
          sh_nxt  = {sh_r[30:0], add_sum[32]};
        end else begin
          acc_nxt = add_sum[31:0];
          sh_nxt  = {1'b0, sh_r[31:1]};
          mc_nxt  = {mc_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = MD_FIX;
        end
      end
      MD_FIX: begin
        // Restore signs: quotient by operand signs, remainder follows the dividend.
        if (is_div_r) begin
          acc_nxt = neg_r_r ? (~acc_r + 32'd1) : acc_r;
          sh_nxt  = neg_q_r ? (~sh_r + 32'd1) : sh_r;
        end
        state_nxt = MD_DONE;
      end
      MD_DONE: begin
        state_nxt = MD_IDLE;
      end
      default: begin
        state_nxt = MD_IDLE;
      end
    endcase
  end

  // Response: the product comes from the accumulator, the quotient from the shift register.
  always_comb begin
    rsp.done      = (state_r == MD_DONE);
    rsp.quotient  = is_div_r ? sh_r : acc_r;
    rsp.remainder = acc_r;
  end

`ifndef NO_ASSERTIONS
  // A start is only honored when the unit is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && state_r == MD_IDLE) |=> (state_r == MD_RUN))
    else $error("muldiv did not start on request");

  // The fix-up step always follows the last iteration.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MD_RUN && cnt_r == LAST_STEP) |=> (state_r == MD_FIX))
    else $error("muldiv skipped sign fix-up");

  // Done lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done)
    else $error("muldiv done held longer than one cycle");
`endif

endmodule : aecc_muldiv

`default_nettype wire

/* rtl/alu_execute_with_condition_codes.sv */
// Top level of the execute unit with condition flags and accumulator.
// A request passes through the EXEC and OUT states; MUL and nonzero DIV also pass through WAIT.
// MUL and nonzero DIV run 32 iterations of one shared adder in the multiply/divide unit, plus setup.
// One request is in flight at a time, so a new request is taken only once the result is in the
// output register; output stalls delay this.
// Synchronous active-low reset clears the flags, the accumulator and all handshake state.
`timescale 1ns / 1ps
`default_nettype none

module alu_execute_with_condition_codes (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata: operand_a[31:0], operand_b[63:32], current_ip[95:64]
  input  wire logic [95:0]  in_tdata,
  // in_tuser: kind[4:0]
  input  wire logic [4:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata: result_a[31:0], write_a[32], result_b[64:33], write_b[65],
  // next_ip[97:66], jump_taken[98], flag_zero[99], flag_negative[100],
  // accumulator_out[132:101], divide_error[133], zero pad[135:134]
  output logic [135:0]      out_tdata
);
  import aecc_pkg::*;

  top_state_t  state_r, state_nxt;
  op_t         op_r;
  logic [31:0] a_r, b_r, ip_r;
  logic        zero_r, zero_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        out_valid_r;
  logic [135:0] out_data_r, out_data_nxt;

  md_req_t     md_req;
  md_rsp_t     md_rsp;

  logic        in_fire, out_load;

  // Result fields computed in the output state.
  logic [31:0] res_a, res_b, res_ip;
  logic        wr_a, wr_b, take, div_err, set_fl;
  logic [31:0] fl_val;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  aecc_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .opa   (a_r),
    .opb   (b_r),
    .rsp   (md_rsp)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and multiply/divide request.
  always_comb begin
    state_nxt     = state_r;
    md_req.start  = 1'b0;
    md_req.is_div = (op_r == OP_DIV);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_MUL || (op_r == OP_DIV && b_r != 32'd0)) begin
          md_req.start = 1'b1;
          state_nxt    = ST_WAIT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_WAIT: begin
        if (md_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= op_t'(in_tuser);
      a_r  <= in_tdata[31:0];
      b_r  <= in_tdata[63:32];
      ip_r <= in_tdata[95:64];
    end
  end

  // Opcode decode and result selection.
  always_comb begin
    res_a   = a_r;
    res_b   = b_r;
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    take    = 1'b0;
    div_err = 1'b0;
    set_fl  = 1'b0;
    fl_val  = 32'd0;
    acc_nxt = acc_r;
    unique case (op_r)
      OP_MOV: begin
        res_a = b_r;
        wr_a  = 1'b1;
      end
      OP_ADD: begin
        res_a = a_r + b_r;
        wr_a  = 1'b1;
        set_fl = 1'b1;
      end
      OP_SUB: begin
        res_a = a_r - b_r;
        wr_a  = 1'b1;
        set_fl = 1'b1;
      end
      OP_SWAP: begin
        res_a = b_r;
        res_b = a_r;
        wr_a  = 1'b1;
        wr_b  = 1'b1;
      end
      OP_MUL: begin
        res_a = md_rsp.quotient;
        wr_a  = 1'b1;
        set_fl = 1'b1;
      end
      OP_DIV: begin
        if (b_r == 32'd0) begin
          div_err = 1'b1;
        end else begin
          res_a   = md_rsp.quotient;
          wr_a    = 1'b1;
          set_fl  = 1'b1;
          acc_nxt = md_rsp.remainder;
        end
      end
      OP_CMP: begin
        set_fl = 1'b1;
        fl_val = a_r - b_r;
      end
      OP_SHL: begin
        res_a = a_r << b_r[4:0];
        wr_a  = 1'b1;
      end
      OP_SHR: begin
        res_a = $unsigned($signed(a_r) >>> b_r[4:0]);
        wr_a  = 1'b1;
      end
      OP_AND: begin
        res_a = a_r & b_r;
        wr_a  = 1'b1;
        set_fl = 1'b1;
      end
      OP_OR: begin
        res_a = a_r | b_r;
        wr_a  = 1'b1;
        set_fl = 1'b1;
      end
      OP_XOR: begin
        res_a = a_r ^ b_r;
        wr_a  = 1'b1;
        set_fl = 1'b1;
      end
      OP_JMP: take = 1'b1;
      OP_JZ:  take = zero_r;
      OP_JP:  take = !zero_r && !neg_r;
      OP_JN:  take = neg_r;
      OP_JNZ: take = !zero_r;
      OP_JNP: take = zero_r || neg_r;
      OP_JNN: take = !neg_r;
      OP_LDL: acc_nxt = (acc_r & SEG_MASK) | (a_r & OFS_MASK);
      OP_LDH: acc_nxt = {a_r[15:0], acc_r[15:0]};
      OP_NOT: begin
        res_a = ~a_r;
        wr_a  = 1'b1;
        set_fl = 1'b1;
      end
      default: begin
      end
    endcase
    // CMP supplies its own flag value; every other flag-setting opcode uses its result.
    if (op_r != OP_CMP) begin
      fl_val = res_a;
    end
    res_ip = take ? ((ip_r & SEG_MASK) + a_r) : ip_r;
    if (set_fl) begin
      zero_nxt = (fl_val == 32'd0);
      neg_nxt  = fl_val[31];
    end else begin
      zero_nxt = zero_r;
      neg_nxt  = neg_r;
    end
    out_data_nxt = {2'b00, div_err, acc_nxt, neg_nxt, zero_nxt, take, res_ip,
                    wr_b, res_b, wr_a, res_a};
  end

  // Architectural state commits when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= 1'b0;
      neg_r  <= 1'b0;
      acc_r  <= 32'd0;
    end else if (out_load) begin
      zero_r <= zero_nxt;
      neg_r  <= neg_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted request always moves on to execution.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted request did not enter execution");

  // The multiply/divide unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == ST_WAIT))
    else $error("muldiv finished outside the wait state");

  // A divide error never writes back operand A.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[133]) |-> !out_data_r[32])
    else $error("divide error with operand write-back");

  // The output register is never overwritten while it still holds an untaken result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost");
`endif

endmodule : alu_execute_with_condition_codes

`default_nettype wire
